### src/ppsch_pkg.sv
// Shared types and constants for the preemptive priority scheduler.
package ppsch_pkg;

    localparam int DEFAULT_NUM_TASKS = 16;

    localparam int TIME_W = 16;
    localparam int PRIO_W = 16;
    localparam int SLOT_W = 4;

    // Stream widths
    localparam int S_TDATA_W = 56;  // slot, arrival, burst, prio, padded to bytes
    localparam int S_TUSER_W = 1;   // func
    localparam int M_TDATA_W = 72;  // run_slot, finish_time, turnaround, waiting, now
    localparam int M_TUSER_W = 3;   // ran, first_run, finished

    localparam logic [TIME_W-1:0] CLOCK_MAX = '1;

    // Item kinds carried in the slave tuser
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // One task slot as held in the table memory
    typedef struct packed {
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] burst;
        logic [PRIO_W-1:0] prio;
        logic [TIME_W-1:0] remaining;
        logic              started;
    } t_task_entry;

endpackage

### src/ppsch_table.sv
// Task table: one synchronous memory with registered read and per-slot valid bits.
module ppsch_table #(
    parameter int NUM_TASKS = ppsch_pkg::DEFAULT_NUM_TASKS,
    parameter int IDX_W     = $clog2(NUM_TASKS)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_rd_en,
    input  logic [IDX_W-1:0]        i_rd_addr,
    output ppsch_pkg::t_task_entry  o_rd_data,
    input  logic                    i_wr_en,
    input  logic [IDX_W-1:0]        i_wr_addr,
    input  ppsch_pkg::t_task_entry  i_wr_data
);
    import ppsch_pkg::*;

    t_task_entry            mem [NUM_TASKS];
    logic [NUM_TASKS-1:0]   r_valid;
    t_task_entry            r_rd_data;
    logic                   r_rd_vld;

    // Storage, no reset
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    // Slot written since reset; an unwritten slot reads as all zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

### src/preemptive_priority_scheduler.sv
// Top level of the preemptive priority scheduler: handshakes, scan sequencer, update.
//
//  Channel   Direction  Handshake                         Payload
//  s_axis    in         i_s_axis_tvalid / o_s_axis_tready tuser: func; tdata: slot, arrival,
//                                                         burst, prio
//  m_axis    out        o_m_axis_tvalid / i_m_axis_tready tuser: ran, first_run, finished;
//                                                         tdata: run_slot, finish_time,
//                                                         turnaround, waiting, now
//
// A load item writes its slot and loads the result register in ST_LOAD, then returns to ST_IDLE.
// A tick item runs the scan: the table memory has one read port, so ST_SCAN reads one slot
// a cycle, then ST_LAST compares the last slot and ST_DONE writes the winner back and
// loads the result register.
// Reset (synchronous, active low) clears the clock, the valid bits of the table and the
// handshake state; slots never loaded since reset read as inactive, so no clearing pass runs.
// A result waiting in the output register stalls only the final step of the next item.
module preemptive_priority_scheduler #(
    parameter int NUM_TASKS = ppsch_pkg::DEFAULT_NUM_TASKS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // slave side
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // [3:0] slot, [19:4] arrival, [35:20] burst, [51:36] prio, [55:52] zero
    input  logic [ppsch_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    // [0] func
    input  logic [ppsch_pkg::S_TUSER_W-1:0] i_s_axis_tuser,
    // master side
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // [3:0] run_slot, [19:4] finish_time, [35:20] turnaround, [51:36] waiting,
    // [67:52] now, [71:68] zero
    output logic [ppsch_pkg::M_TDATA_W-1:0] o_m_axis_tdata,
    // [0] ran, [1] first_run, [2] finished
    output logic [ppsch_pkg::M_TUSER_W-1:0] o_m_axis_tuser
);
    import ppsch_pkg::*;

    localparam int IDX_W = $clog2(NUM_TASKS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TASKS - 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LOAD = 3'd1;
    localparam logic [2:0] ST_SCAN = 3'd2;
    localparam logic [2:0] ST_LAST = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]         r_state, n_state;

    // Captured input item
    logic               r_func;
    logic [SLOT_W-1:0]  r_slot;
    logic [TIME_W-1:0]  r_arrival;
    logic [TIME_W-1:0]  r_burst;
    logic [PRIO_W-1:0]  r_prio;

    logic [TIME_W-1:0]  r_now;

    // Scan state
    logic [IDX_W-1:0]   r_ptr;
    logic               r_cmp_vld;
    logic [IDX_W-1:0]   r_cmp_idx;
    logic               r_found;
    logic [IDX_W-1:0]   r_best_idx;
    t_task_entry        r_best;

    // Output register
    logic                   r_m_tvalid;
    logic [M_TDATA_W-1:0]   r_m_tdata;
    logic [M_TUSER_W-1:0]   r_m_tuser;

    // Table port signals
    logic               tbl_rd_en;
    t_task_entry        tbl_rd_data;
    logic               tbl_wr_en;
    logic [IDX_W-1:0]   tbl_wr_addr;
    t_task_entry        tbl_wr_data;

    logic               in_accept;
    logic               out_free;
    logic               slot_in_range;
    logic               cand_elig;
    logic               cand_better;
    logic [TIME_W-1:0]  now_next;
    logic [TIME_W-1:0]  rem_dec;
    logic               fin;
    logic [TIME_W-1:0]  tat;
    logic [TIME_W-1:0]  wt;
    logic [TIME_W-1:0]  tick_finish;
    logic [TIME_W-1:0]  tick_tat;
    logic [TIME_W-1:0]  tick_wt;

    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_m_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_m_tvalid;
    assign o_m_axis_tdata  = r_m_tdata;
    assign o_m_axis_tuser  = r_m_tuser;

    assign slot_in_range = (32'(r_slot) < NUM_TASKS);

    // Candidate test on the slot read out last cycle; ascending scan keeps the lower slot on a tie
    assign cand_elig   = (tbl_rd_data.remaining != '0) && (tbl_rd_data.arrival <= r_now);
    assign cand_better = !r_found
                      || ($signed(tbl_rd_data.prio) > $signed(r_best.prio))
                      || ((tbl_rd_data.prio == r_best.prio)
                          && (tbl_rd_data.arrival < r_best.arrival));

    // Update arithmetic for the winner
    assign now_next = (r_now == CLOCK_MAX) ? r_now : r_now + 1'b1;
    assign rem_dec  = r_best.remaining - 1'b1;
    assign fin      = r_found && (rem_dec == '0);
    assign tat      = now_next - r_best.arrival;
    assign wt       = (tat >= r_best.burst) ? tat - r_best.burst : '0;

    assign tick_finish = fin ? now_next : '0;
    assign tick_tat    = fin ? tat : '0;
    assign tick_wt     = fin ? wt : '0;

    // Table access: scan reads, load or write-back writes
    always_comb begin
        tbl_rd_en   = (r_state == ST_SCAN);
        tbl_wr_en   = 1'b0;
        tbl_wr_addr = r_best_idx;
        tbl_wr_data = r_best;
        unique case (r_state)
            ST_LOAD: begin
                tbl_wr_en   = out_free && slot_in_range;
                tbl_wr_addr = IDX_W'(r_slot);
                tbl_wr_data = '{arrival:   r_arrival,
                                burst:     r_burst,
                                prio:      r_prio,
                                remaining: r_burst,
                                started:   1'b0};
            end
            ST_DONE: begin
                tbl_wr_en             = out_free && r_found;
                tbl_wr_data.remaining = rem_dec;
                tbl_wr_data.started   = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_state = (i_s_axis_tuser[0] == FUNC_LOAD) ? ST_LOAD : ST_SCAN;
                end
            end
            ST_LOAD: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (r_ptr == LAST_IDX) begin
                    n_state = ST_LAST;
                end
            end
            ST_LAST: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_now      <= '0;
            r_cmp_vld  <= 1'b0;
            r_found    <= 1'b0;
            r_ptr      <= '0;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= (r_state == ST_SCAN);

            // Hold a stalled result, raise valid when a load or tick completes
            r_m_tvalid <= (r_m_tvalid && !i_m_axis_tready)
                       || (out_free && (r_state == ST_LOAD || r_state == ST_DONE));

            unique case (r_state)
                ST_IDLE: begin
                    r_ptr   <= '0;
                    r_found <= 1'b0;
                end
                ST_SCAN: begin
                    r_ptr <= r_ptr + 1'b1;
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_now <= now_next;
                    end
                end
                default: begin
                end
            endcase

            // Take the candidate if it beats the best so far
            if (r_cmp_vld && cand_elig && cand_better) begin
                r_found <= 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_func    <= i_s_axis_tuser[0];
            r_slot    <= i_s_axis_tdata[3:0];
            r_arrival <= i_s_axis_tdata[19:4];
            r_burst   <= i_s_axis_tdata[35:20];
            r_prio    <= i_s_axis_tdata[51:36];
        end

        r_cmp_idx <= r_ptr;
        if (r_cmp_vld && cand_elig && cand_better) begin
            r_best_idx <= r_cmp_idx;
            r_best     <= tbl_rd_data;
        end

        if (out_free && (r_state == ST_LOAD || r_state == ST_DONE)) begin
            if (r_func == FUNC_TICK && r_found) begin
                r_m_tuser <= {fin, !r_best.started, 1'b1};
                r_m_tdata <= {4'b0, now_next, tick_wt, tick_tat, tick_finish,
                              SLOT_W'(r_best_idx)};
            end else if (r_func == FUNC_TICK) begin
                // Idle tick: only the clock moves
                r_m_tuser <= '0;
                r_m_tdata <= {4'b0, now_next, {(3*TIME_W + SLOT_W){1'b0}}};
            end else begin
                r_m_tuser <= '0;
                r_m_tdata <= {4'b0, r_now, {(3*TIME_W + SLOT_W){1'b0}}};
            end
        end
    end

    ppsch_table #(
        .NUM_TASKS (NUM_TASKS),
        .IDX_W     (IDX_W)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (tbl_rd_en),
        .i_rd_addr (r_ptr),
        .o_rd_data (tbl_rd_data),
        .i_wr_en   (tbl_wr_en),
        .i_wr_addr (tbl_wr_addr),
        .i_wr_data (tbl_wr_data)
    );

endmodule

### src/ppsch_checker.sv
// Port-level checks for the scheduler and their binding to the top level.
module ppsch_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_tvalid,
    input logic                            i_s_tready,
    input logic                            i_m_tvalid,
    input logic                            i_m_tready,
    input logic [ppsch_pkg::M_TDATA_W-1:0] i_m_tdata,
    input logic [ppsch_pkg::M_TUSER_W-1:0] i_m_tuser
);
    import ppsch_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && !i_m_tready) |=> (i_m_tvalid && $stable(i_m_tdata)
                                         && $stable(i_m_tuser)))
        else $error("stalled result changed");

    // One item in flight: drop ready after an acceptance
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && i_s_tready) |=> !i_s_tready)
        else $error("input accepted while an item is in flight");

    // A finished task must have run, finishes at the reported clock, and waits no longer than its turnaround
    a_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && i_m_tuser[2]) |-> (i_m_tuser[0] && (i_m_tdata[19:4] == i_m_tdata[67:52])
                                          && (i_m_tdata[51:36] <= i_m_tdata[35:20])))
        else $error("finish fields inconsistent");

    // Without a served task the slot and times stay zero
    a_idle_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && !i_m_tuser[0]) |-> ((i_m_tuser == '0) && (i_m_tdata[51:0] == '0)))
        else $error("fields set without a served task");

endmodule

bind preemptive_priority_scheduler ppsch_checker u_ppsch_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_axis_tvalid),
    .i_s_tready (o_s_axis_tready),
    .i_m_tvalid (o_m_axis_tvalid),
    .i_m_tready (i_m_axis_tready),
    .i_m_tdata  (o_m_axis_tdata),
    .i_m_tuser  (o_m_axis_tuser)
);

### tb/sv/tb_preemptive_priority_scheduler.sv
// Self-checking testbench for the preemptive priority scheduler.
module tb_preemptive_priority_scheduler;
    import ppsch_pkg::*;

    localparam int NUM_SLOTS    = DEFAULT_NUM_TASKS;
    localparam int RANDOM_ITEMS = 1700;
    // Slowest correct run: ~1.8k items, each with its full scan plus the longest gap
    // and the longest stall; the limit takes that five times over.
    localparam int LIMIT_CYCLES = 1_000_000;
    // Allow a good margin, well past the length of one tick, after the last result.
    localparam int DRAIN_CYCLES = 4 * (NUM_SLOTS + 3);

    // One input item as the driver sees it
    typedef struct packed {
        logic                     func;
        logic [SLOT_W-1:0]        slot;
        logic [TIME_W-1:0]        arrival;
        logic [TIME_W-1:0]        burst;
        logic signed [PRIO_W-1:0] prio;
    } t_sched_req;

    // One result item, unpacked from tuser and tdata
    typedef struct packed {
        logic              ran;
        logic              first_run;
        logic              finished;
        logic [SLOT_W-1:0] run_slot;
        logic [TIME_W-1:0] finish_time;
        logic [TIME_W-1:0] turnaround;
        logic [TIME_W-1:0] waiting;
        logic [TIME_W-1:0] now;
    } t_tick_report;

    // Mirror of the task table: predicts the report of every accepted item and
    // checks the reports that leave the block in order.
    class sched_tracker;
        logic [TIME_W-1:0]        arrival_tab [NUM_SLOTS];
        logic [TIME_W-1:0]        burst_tab   [NUM_SLOTS];
        logic signed [PRIO_W-1:0] prio_tab    [NUM_SLOTS];
        logic [TIME_W-1:0]        left_tab    [NUM_SLOTS];
        bit                       started_tab [NUM_SLOTS];
        logic [TIME_W-1:0]        sched_time;
        t_tick_report             due_reports [$];
        int                       errors;

        function new();
            for (int i = 0; i < NUM_SLOTS; i++) begin
                arrival_tab[i] = '0;
                burst_tab[i]   = '0;
                prio_tab[i]    = '0;
                left_tab[i]    = '0;
                started_tab[i] = 1'b0;
            end
            sched_time = '0;
            errors     = 0;
        endfunction

        function void step_time();
            if (sched_time != CLOCK_MAX)
                sched_time = sched_time + 1'b1;
        endfunction

        // Apply one accepted item to the table and queue the report it must produce
        function void note_item(t_sched_req req);
            t_tick_report rep;
            int           best;
            bit           found;
            logic [TIME_W-1:0] tat;
            rep   = '0;
            best  = 0;
            found = 1'b0;
            if (req.func == FUNC_LOAD) begin
                if (int'(req.slot) < NUM_SLOTS) begin
                    arrival_tab[req.slot] = req.arrival;
                    burst_tab[req.slot]   = req.burst;
                    prio_tab[req.slot]    = req.prio;
                    left_tab[req.slot]    = req.burst;
                    started_tab[req.slot] = 1'b0;
                end
                rep.now = sched_time;
                due_reports.push_back(rep);
                return;
            end
            // Pick the eligible task: highest priority, then earliest arrival, then lowest slot
            for (int i = 0; i < NUM_SLOTS; i++) begin
                if (left_tab[i] == 0 || arrival_tab[i] > sched_time)
                    continue;
                if (!found || prio_tab[i] > prio_tab[best] ||
                    (prio_tab[i] == prio_tab[best] && arrival_tab[i] < arrival_tab[best])) begin
                    best  = i;
                    found = 1'b1;
                end
            end
            if (found) begin
                rep.ran       = 1'b1;
                rep.run_slot  = best[SLOT_W-1:0];
                rep.first_run = !started_tab[best];
                started_tab[best] = 1'b1;
            end
            step_time();
            if (found) begin
                left_tab[best] = left_tab[best] - 1'b1;
                if (left_tab[best] == 0) begin
                    tat             = sched_time - arrival_tab[best];
                    rep.finished    = 1'b1;
                    rep.finish_time = sched_time;
                    rep.turnaround  = tat;
                    // a saturated clock can leave turnaround below the burst: clamp at zero
                    rep.waiting     = (tat >= burst_tab[best]) ? tat - burst_tab[best] : '0;
                end
            end
            rep.now = sched_time;
            due_reports.push_back(rep);
        endfunction

        function void match(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected %0d, got %0d", field, want, got);
                errors++;
            end
        endfunction

        function void check_item(logic [M_TUSER_W-1:0] tuser, logic [M_TDATA_W-1:0] tdata);
            t_tick_report want;
            if (due_reports.size() == 0) begin
                $error("result item arrived with no report outstanding");
                errors++;
                return;
            end
            want = due_reports.pop_front();
            match("ran",         32'(want.ran),         32'(tuser[0]));
            match("first_run",   32'(want.first_run),   32'(tuser[1]));
            match("finished",    32'(want.finished),    32'(tuser[2]));
            match("run_slot",    32'(want.run_slot),    32'(tdata[3:0]));
            match("finish_time", 32'(want.finish_time), 32'(tdata[19:4]));
            match("turnaround",  32'(want.turnaround),  32'(tdata[35:20]));
            match("waiting",     32'(want.waiting),     32'(tdata[51:36]));
            match("now",         32'(want.now),         32'(tdata[67:52]));
        endfunction

        function int outstanding();
            return due_reports.size();
        endfunction
    endclass

    // Clock, reset and the block's ports; every input known from time zero
    logic                 i_clk    = 1'b0;
    logic                 i_rst_n  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [S_TUSER_W-1:0] s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    // Set to hold both sides busy: no gaps, no stalls
    bit           quiet = 1'b0;
    int           cycles = 0;
    sched_tracker sb;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    preemptive_priority_scheduler DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    // Gap length for either side: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet)
            return 0;
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic t_sched_req load_req(int slot, int arrival, int burst, int prio);
        t_sched_req r;
        r.func    = FUNC_LOAD;
        r.slot    = slot[SLOT_W-1:0];
        r.arrival = arrival[TIME_W-1:0];
        r.burst   = burst[TIME_W-1:0];
        r.prio    = prio[PRIO_W-1:0];
        return r;
    endfunction

    function automatic t_sched_req tick_req();
        t_sched_req r;
        r      = '0;
        r.func = FUNC_TICK;
        // random payload: a tick must ignore it
        r.slot    = SLOT_W'($urandom_range(0, 15));
        r.arrival = TIME_W'($urandom);
        r.burst   = TIME_W'($urandom);
        r.prio    = PRIO_W'($urandom);
        return r;
    endfunction

    // Offer one item, hold it until accepted, then record it with the tracker.
    // Called at a rising edge; tvalid stays high straight into the next item when no gap falls.
    task automatic offer_item(t_sched_req r);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.func;
        s_tdata  <= {4'b0000, r.prio, r.burst, r.arrival, r.slot};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        sb.note_item(r);
    endtask

    // Result side: check each accepted item, then choose ready for the next edge
    initial begin : result_sink
        int stall;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (m_tvalid && m_tready)
                sb.check_item(m_tuser, m_tdata);
            if (quiet) begin
                m_tready <= 1'b1;
            end else if (stall > 0) begin
                stall--;
                m_tready <= 1'b0;
            end else begin
                stall = pick_gap();
                m_tready <= (stall == 0);
                if (stall > 0)
                    stall--;
            end
        end
    end

    // Watchdog: end the run if the block hangs
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin : stimulus
        t_sched_req r;
        int         base;
        int         sel;
        int         arr;
        int         bst;
        int         pri;
        sb = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: idle tick on an empty table
        offer_item(tick_req());
        // Lowest priority with the longest burst: runs only when nothing else can
        offer_item(load_req(0, 0, 16'hFFFF, -32768));
        offer_item(tick_req());
        // Highest priority arrives and preempts, then completes
        offer_item(load_req(15, 1, 2, 32767));
        offer_item(tick_req());
        offer_item(tick_req());
        // Back to slot 0: no longer a first run
        offer_item(tick_req());
        // Equal priorities: earlier arrival first, then lower slot
        offer_item(load_req(9, 2, 1, 5));
        offer_item(load_req(7, 1, 1, 5));
        offer_item(load_req(3, 1, 1, 5));
        offer_item(tick_req());
        offer_item(tick_req());
        offer_item(tick_req());
        // Zero burst leaves the slot inactive
        offer_item(load_req(4, 0, 0, 32767));
        offer_item(tick_req());
        // Arrival far ahead: not eligible yet
        offer_item(load_req(5, 16'hFFFF, 1, 32767));
        offer_item(tick_req());
        // Reload a pending slot: fresh burst and first run again
        offer_item(load_req(0, 0, 1, 0));
        offer_item(tick_req());
        offer_item(tick_req());

        // Random: loads near the current time so tasks compete, with ties and noise
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // hold both sides busy for a stretch
            quiet = (n >= 600 && n < 800);
            if ($urandom_range(0, 99) < 60) begin
                r = tick_req();
            end else begin
                base = int'(sb.sched_time);
                sel  = $urandom_range(0, 99);
                if (sel < 50)
                    arr = (base > 4 ? base - 4 : 0) + $urandom_range(0, 10);
                else if (sel < 70)
                    arr = base + 2 * $urandom_range(0, 1);
                else if (sel < 90)
                    arr = $urandom_range(0, 65535);
                else
                    arr = 0;
                sel = $urandom_range(0, 99);
                if (sel < 10)
                    bst = 0;
                else if (sel < 80)
                    bst = $urandom_range(1, 6);
                else if (sel < 95)
                    bst = $urandom_range(7, 40);
                else
                    bst = $urandom_range(0, 65535);
                sel = $urandom_range(0, 99);
                if (sel < 40)
                    pri = $urandom_range(0, 3) - 1;
                else if (sel < 95)
                    pri = $urandom_range(0, 65535) - 32768;
                else
                    pri = sel[0] ? 32767 : -32768;
                r = load_req($urandom_range(0, 15), arr, bst, pri);
            end
            offer_item(r);
        end

        // Close with a back-to-back stretch of ticks, then one with gaps
        quiet = 1'b1;
        repeat (20) offer_item(tick_req());
        quiet = 1'b0;
        repeat (20) offer_item(tick_req());

        // Drop valid, wait for every report, then watch for strays
        s_tvalid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### filelist.f
src/ppsch_pkg.sv
src/ppsch_table.sv
src/preemptive_priority_scheduler.sv
src/ppsch_checker.sv
tb/sv/tb_preemptive_priority_scheduler.sv
